// ===== rtl/lphg_pkg.sv =====
// Shared constants and types for the landmark pair hash generator.
// No dependencies; lphg_if, lphg_pair_eval, the top level and the testbench use it.
`timescale 1ns / 1ps
`default_nettype none

package lphg_pkg;

  // Field widths
  localparam int unsigned BinBits   = 9;    // stored anchor / target bin
  localparam int unsigned DeltaBits = 14;   // frame delta inside the hash
  localparam int unsigned BinInW    = 12;   // bin field of an incoming peak
  localparam int unsigned HashW     = 32;
  localparam int unsigned OutFrameW = 32;   // anchor frame on the result beat
  localparam int unsigned ResultCap = 32;   // most results per peak

  // Default sizing
  localparam int unsigned DefMaxTargets = 32;
  localparam int unsigned DefFrameWidth = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned BinLimW  = 10;
  localparam int unsigned TpaW     = 6;
  localparam int unsigned OffLimW  = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBinLimit  = 2'd0,
    CfgTargets   = 2'd1,
    CfgOffsetLim = 2'd2
  } cfg_idx_e;

  localparam logic [BinLimW-1:0] RstBinLimit  = 10'd512;
  localparam logic [TpaW-1:0]    RstTargets   = 6'd5;
  localparam logic [OffLimW-1:0] RstOffsetLim = 14'd200;

  // One result beat without its run flag
  typedef struct packed {
    logic [HashW-1:0]     pair_hash;
    logic [OutFrameW-1:0] anchor_frame;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lphg_if.sv =====
// Valid/ready channel interfaces: peaks in, pair hashes out.
// Depends on lphg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lphg_peak_if #(
  parameter int unsigned FRAME_WIDTH = lphg_pkg::DefFrameWidth
);
  logic                         valid;
  logic                         ready;
  logic [FRAME_WIDTH-1:0]       frame_number;
  logic [lphg_pkg::BinInW-1:0]  bin_number;
  logic                         track_start;

  modport source (output valid, output frame_number, output bin_number,
                  output track_start, input ready);
  modport sink   (input valid, input frame_number, input bin_number,
                  input track_start, output ready);
endinterface

interface lphg_hash_if;
  logic                           valid;
  logic                           ready;
  logic [lphg_pkg::HashW-1:0]     pair_hash;
  logic [lphg_pkg::OutFrameW-1:0] anchor_frame;
  logic                           run_last;

  modport source (output valid, output pair_hash, output anchor_frame,
                  output run_last, input ready);
  modport sink   (input valid, input pair_hash, input anchor_frame,
                  input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/lphg_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lphg_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lphg_pair_eval.sv =====
// Pair check and hash packing for one anchor/target pair.
// Depends on lphg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lphg_pair_eval #(
  parameter int unsigned FRAME_WIDTH = lphg_pkg::DefFrameWidth
) (
  input  wire logic [FRAME_WIDTH-1:0]       tgt_frame_i,
  input  wire logic [lphg_pkg::BinBits-1:0] tgt_bin_i,
  input  wire logic [FRAME_WIDTH-1:0]       anc_frame_i,
  input  wire logic [lphg_pkg::BinBits-1:0] anc_bin_i,
  input  wire logic [lphg_pkg::OffLimW-1:0] offset_limit_i,
  output logic                              pass_o,
  output lphg_pkg::result_t                 result_o
);
  import lphg_pkg::*;

  logic [FRAME_WIDTH-1:0] delta;
  logic [63:0]            anc_frame_ext;

  // wraps modulo 2^FRAME_WIDTH; a backwards frame gives a huge delta
  assign delta         = tgt_frame_i - anc_frame_i;
  assign pass_o        = (delta <= FRAME_WIDTH'(offset_limit_i));
  assign anc_frame_ext = 64'(anc_frame_i);

  assign result_o.pair_hash    = {anc_bin_i, tgt_bin_i, delta[DeltaBits-1:0]};
  assign result_o.anchor_frame = anc_frame_ext[OutFrameW-1:0];

endmodule

`default_nettype wire

// ===== rtl/landmark_pair_hash_generator.sv =====
// Landmark pair hash generator: top level with sequencer and anchor ring.
// Depends on lphg_pkg, lphg_if, lphg_ram and lphg_pair_eval.
//
// Usage:
//   peak_in carries one spectral peak per beat (frame, bin, track_start).
//   hash_out carries the pair hashes caused by that peak, oldest anchor
//   first; run_last marks the final hash of the peak. A peak that makes no
//   pair, or whose bin is at or above bin_limit, gives no beat at all.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while the block is idle.
// Timing:
//   The block works on one peak at a time. A peak with anchors in use
//   passes an accept cycle, one anchor-ring read per cycle through the
//   single read port of the ring RAM while no passing pair waits for
//   room, the registered read of the last anchor and a store of the new
//   anchor before the next peak is let in. With no anchor in use the
//   accept is followed by the store alone; a dropped peak ends at its accept.
//   A hash waits in the hold register until the next passing pair is
//   read or the run ends, and then moves to the output register.
// Reset and stall:
//   Reset empties the anchor window and loads the register defaults; the
//   ring RAM itself is not cleared, as only written entries are read.
//   When hash_out stalls, one result waits in the output register and one
//   in the hold register; ring reads pause while a passing pair waits.
`timescale 1ns / 1ps
`default_nettype none

module landmark_pair_hash_generator #(
  parameter int unsigned MAX_TARGETS = lphg_pkg::DefMaxTargets,
  parameter int unsigned FRAME_WIDTH = lphg_pkg::DefFrameWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lphg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lphg_pkg::CfgDataW-1:0] cfg_data_i,
  lphg_peak_if.sink                          peak_in,
  lphg_hash_if.source                        hash_out
);
  import lphg_pkg::*;

  localparam int unsigned AddrW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_TARGETS + 1);
  localparam int unsigned UseCap = (MAX_TARGETS < ResultCap) ? MAX_TARGETS : ResultCap;
  localparam int unsigned EntryW = FRAME_WIDTH + BinBits;

  localparam logic [AddrW-1:0] LastSlot = AddrW'(MAX_TARGETS - 1);
  localparam logic [CntW:0]    DepthW1  = (CntW + 1)'(MAX_TARGETS);

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // ---------------------------------------------------------------------
  // configuration registers
  logic [BinLimW-1:0] bin_limit_q;
  logic [TpaW-1:0]    tpa_q;
  logic [OffLimW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_limit_q <= RstBinLimit;
      tpa_q       <= RstTargets;
      offset_q    <= RstOffsetLim;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgBinLimit:  bin_limit_q <= cfg_data_i[BinLimW-1:0];
        CfgTargets:   tpa_q       <= cfg_data_i[TpaW-1:0];
        CfgOffsetLim: offset_q    <= cfg_data_i[OffLimW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // state
  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;      // anchors in the ring
  logic [AddrW-1:0]       slot_q, slot_d;        // next write slot
  logic [CntW-1:0]        use_q, use_d;          // anchors to pair this peak
  logic [CntW-1:0]        rd_cnt_q, rd_cnt_d;    // reads issued
  logic [AddrW-1:0]       rd_addr_q, rd_addr_d;
  logic                   pend_q, pend_d;        // read data waiting
  logic [FRAME_WIDTH-1:0] frame_q, frame_d;
  logic [BinBits-1:0]     bin_q, bin_d;
  logic                   hold_v_q, hold_v_d;
  result_t                hold_q, hold_d;
  logic                   out_v_q, out_v_d;
  result_t                out_q;
  logic                   out_last_q;

  // ---------------------------------------------------------------------
  // anchor ring and pair check
  logic              ram_we, ram_re;
  logic [EntryW-1:0] ram_rdata;
  logic              pair_pass;
  result_t           pair_res;

  lphg_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_TARGETS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i ({frame_q, bin_q}),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  lphg_pair_eval #(
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_eval (
    .tgt_frame_i    (frame_q),
    .tgt_bin_i      (bin_q),
    .anc_frame_i    (ram_rdata[EntryW-1:BinBits]),
    .anc_bin_i      (ram_rdata[BinBits-1:0]),
    .offset_limit_i (offset_q),
    .pass_o         (pair_pass),
    .result_o       (pair_res)
  );

  // ---------------------------------------------------------------------
  // accept-time decode
  logic [BinLimW-1:0] lim_eff;
  logic               drop;
  logic [CntW-1:0]    cnt_eff;
  logic [AddrW-1:0]   slot_eff;
  logic [6:0]         use_w;
  logic [CntW-1:0]    use_n;
  logic [CntW:0]      start_w;
  logic [AddrW-1:0]   start_n;
  logic               accept;

  assign lim_eff  = (bin_limit_q > BinLimW'(1 << BinBits)) ? BinLimW'(1 << BinBits)
                                                           : bin_limit_q;
  assign drop     = (peak_in.bin_number >= BinInW'(lim_eff));
  assign cnt_eff  = peak_in.track_start ? '0 : count_q;
  assign slot_eff = peak_in.track_start ? '0 : slot_q;

  always_comb begin
    use_w = 7'(tpa_q);
    if (use_w > 7'(UseCap)) begin
      use_w = 7'(UseCap);
    end
    if (use_w > 7'(cnt_eff)) begin
      use_w = 7'(cnt_eff);
    end
  end
  assign use_n = CntW'(use_w);

  // oldest anchor in use: slot - use, modulo the ring depth
  always_comb begin
    start_w = (CntW + 1)'(slot_eff) + DepthW1 - (CntW + 1)'(use_n);
    if (start_w >= DepthW1) begin
      start_w = start_w - DepthW1;
    end
  end
  assign start_n = AddrW'(start_w);

  assign peak_in.ready = (state_q == StIdle);
  assign accept        = peak_in.valid && peak_in.ready;

  // ---------------------------------------------------------------------
  // sequencer
  logic out_free, consume, advance, issue;
  logic load_out, load_last;

  assign out_free = !out_v_q || hash_out.ready;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    slot_d    = slot_q;
    use_d     = use_q;
    rd_cnt_d  = rd_cnt_q;
    rd_addr_d = rd_addr_q;
    pend_d    = pend_q;
    frame_d   = frame_q;
    bin_d     = bin_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load_out  = 1'b0;
    load_last = 1'b0;
    consume   = 1'b0;
    advance   = 1'b0;
    issue     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          count_d   = cnt_eff;
          slot_d    = slot_eff;
          frame_d   = peak_in.frame_number;
          bin_d     = peak_in.bin_number[BinBits-1:0];
          use_d     = use_n;
          rd_cnt_d  = '0;
          rd_addr_d = start_n;
          pend_d    = 1'b0;
          if (!drop) begin
            state_d = (use_n == '0) ? StDone : StRun;
          end
        end
      end

      StRun: begin
        // a passing pair needs room only when the hold register is full
        consume = pend_q && (!pair_pass || !hold_v_q || out_free);
        advance = !pend_q || consume;
        if (consume && pair_pass) begin
          load_out = hold_v_q;
          hold_d   = pair_res;
          hold_v_d = 1'b1;
        end
        issue = advance && (rd_cnt_q != use_q);
        if (issue) begin
          ram_re    = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          rd_addr_d = (rd_addr_q == LastSlot) ? '0 : rd_addr_q + 1'b1;
        end
        pend_d = issue || (pend_q && !consume);
        if (!issue && advance && (rd_cnt_q == use_q)) begin
          state_d = StDone;
        end
      end

      StDone: begin
        // flush the last hash of the run and store the new anchor
        if (!hold_v_q || out_free) begin
          load_out  = hold_v_q;
          load_last = 1'b1;
          hold_v_d  = 1'b0;
          ram_we    = 1'b1;
          slot_d    = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
          if (count_q != CntW'(MAX_TARGETS)) begin
            count_d = count_q + 1'b1;
          end
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_v_d = load_out ? 1'b1 : (hash_out.ready ? 1'b0 : out_v_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      slot_q    <= '0;
      use_q     <= '0;
      rd_cnt_q  <= '0;
      rd_addr_q <= '0;
      pend_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      slot_q    <= slot_d;
      use_q     <= use_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_addr_q <= rd_addr_d;
      pend_q    <= pend_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    bin_q   <= bin_d;
    hold_q  <= hold_d;
    if (load_out) begin
      out_q      <= hold_q;
      out_last_q <= load_last;
    end
  end

  // result beat
  assign hash_out.valid        = out_v_q;
  assign hash_out.pair_hash    = out_q.pair_hash;
  assign hash_out.anchor_frame = out_q.anchor_frame;
  assign hash_out.run_last     = out_last_q;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for landmark_pair_hash_generator: drives peaks, predicts the
// pair hash beats with a scoreboard class and checks every result beat on the output.
// Depends on lphg_pkg, lphg_if and the block's RTL; nothing else.
`timescale 1ns / 1ps

module tb;
  import lphg_pkg::*;

  localparam int unsigned MaxTargets     = DefMaxTargets;
  localparam int unsigned FrameW         = DefFrameWidth;
  localparam int unsigned SlotW          = $clog2(DefMaxTargets);
  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned TailCycles     = DefMaxTargets + 8;
  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned ErrorPrintCap  = 30;
  localparam int unsigned PhaseKept      = 40;
  localparam int unsigned PhaseCnt       = 8;
  localparam int unsigned HoldAfterBeats = 150;
  localparam int unsigned HoldCycles     = 400;

  // One expected hash beat
  typedef struct {
    result_t res;
    logic    run_last;
  } hash_beat_t;

  typedef enum int {RxOpen, RxCoin, RxMostly, RxSparse} rx_mode_e;

  // Anchor window model plus queue of hash beats still owed by the block
  class hash_scoreboard;
    logic [FrameW-1:0]  anchor_frame_ring [MaxTargets];
    logic [BinBits-1:0] anchor_bin_ring [MaxTargets];
    int unsigned        anchors_held;
    logic [SlotW-1:0]   next_slot;
    logic [BinLimW-1:0] bin_limit;
    logic [TpaW-1:0]    targets_per_anchor;
    logic [OffLimW-1:0] offset_limit;
    hash_beat_t         pending_hashes[$];
    int unsigned        errors;

    function new();
      anchors_held       = 0;
      next_slot          = '0;
      bin_limit          = RstBinLimit;
      targets_per_anchor = RstTargets;
      offset_limit       = RstOffsetLim;
      errors             = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgBinLimit:  bin_limit          = data[BinLimW-1:0];
        CfgTargets:   targets_per_anchor = data[TpaW-1:0];
        CfgOffsetLim: offset_limit       = data[OffLimW-1:0];
        default: ;
      endcase
    endfunction

    // Limits above the 9-bit bin range behave as the full range
    function int unsigned kept_limit();
      return (bin_limit > (1 << BinBits)) ? (1 << BinBits) : int'(bin_limit);
    endfunction

    function int unsigned pending();
      return pending_hashes.size();
    endfunction

    // Pair an accepted, kept peak with the latest anchors, oldest first, then store it
    function void predict_pairs(logic [FrameW-1:0] frame, logic [BinInW-1:0] bin,
                                logic start);
      int unsigned       anchors_used;
      logic [SlotW-1:0]  slot;
      logic [FrameW-1:0] delta;
      hash_beat_t        beat;
      bit                have_beat;
      if (start) begin
        anchors_held = 0;
        next_slot    = '0;
      end
      if (bin >= kept_limit()) return;
      anchors_used = 32'(targets_per_anchor);
      if (anchors_used > MaxTargets) anchors_used = MaxTargets;
      if (anchors_used > ResultCap) anchors_used = ResultCap;
      if (anchors_used > anchors_held) anchors_used = anchors_held;
      slot      = next_slot - anchors_used[SlotW-1:0];
      have_beat = 1'b0;
      for (int unsigned k = 0; k < anchors_used; k++) begin
        // wrapped distance: a backwards frame gives a huge delta and is skipped
        delta = frame - anchor_frame_ring[slot];
        if (delta <= offset_limit) begin
          if (have_beat) pending_hashes = {pending_hashes, beat};
          beat.res.pair_hash    = {anchor_bin_ring[slot], bin[BinBits-1:0],
                                   delta[DeltaBits-1:0]};
          beat.res.anchor_frame = anchor_frame_ring[slot];
          beat.run_last         = 1'b0;
          have_beat             = 1'b1;
        end
        slot = slot + 1'b1;
      end
      if (have_beat) begin
        beat.run_last = 1'b1;
        pending_hashes = {pending_hashes, beat};
      end
      anchor_frame_ring[next_slot] = frame;
      anchor_bin_ring[next_slot]   = bin[BinBits-1:0];
      next_slot = next_slot + 1'b1;
      if (anchors_held < MaxTargets) anchors_held++;
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (errors < ErrorPrintCap)
        $error("%s mismatch: expected %h, got %h", field, want, got);
      errors++;
    endfunction

    function void check_hash(logic [HashW-1:0] hash, logic [OutFrameW-1:0] aframe,
                             logic last);
      hash_beat_t want;
      if (pending_hashes.size() == 0) begin
        if (errors < ErrorPrintCap)
          $error("hash beat %h (anchor frame %h) with nothing pending", hash, aframe);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      if (want.res.pair_hash !== hash) report("pair_hash", want.res.pair_hash, hash);
      if (want.res.anchor_frame !== aframe)
        report("anchor_frame", want.res.anchor_frame, aframe);
      if (want.run_last !== last) report("run_last", 32'(want.run_last), 32'(last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         cycle_cnt = 0;

  lphg_peak_if #(.FRAME_WIDTH(FrameW)) peak_if ();
  lphg_hash_if hash_if ();

  landmark_pair_hash_generator #(
    .MAX_TARGETS(MaxTargets),
    .FRAME_WIDTH(FrameW)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .peak_in   (peak_if.sink),
    .hash_out  (hash_if.source)
  );

  hash_scoreboard sb = new();

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Run-away guard
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("** landmark_pair_hash_generator: FAILED **");
    $finish;
  end

  // Result side: check each beat, stall on a changing pattern, one long hold-off
  int unsigned rx_beats  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  rx_mode_e    rx_mode   = RxOpen;
  int unsigned mode_left = 0;

  initial begin
    hash_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hash_if.valid === 1'b1 && hash_if.ready === 1'b1) begin
        sb.check_hash(hash_if.pair_hash, hash_if.anchor_frame, hash_if.run_last);
        rx_beats++;
      end
      if (!hold_done && rx_beats >= HoldAfterBeats) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        hash_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxOpen:   hash_if.ready <= 1'b1;
          RxCoin:   hash_if.ready <= 1'($urandom_range(0, 1));
          RxMostly: hash_if.ready <= ($urandom_range(0, 7) != 0);
          default:  hash_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offer one peak and hold it until accepted; call at a rising edge
  task automatic send_peak(logic [FrameW-1:0] frame, logic [BinInW-1:0] bin,
                           logic start);
    peak_if.valid        <= 1'b1;
    peak_if.frame_number <= frame;
    peak_if.bin_number   <= bin;
    peak_if.track_start  <= start;
    do @(posedge clk); while (peak_if.ready !== 1'b1);
    sb.predict_pairs(frame, bin, start);
  endtask

  // Let all owed beats drain, then give the block time to finish silent peaks
  task automatic wait_idle();
    peak_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; only while idle
  task automatic set_config(int unsigned bl, int unsigned tpa, int unsigned off);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBinLimit;
    cfg_data <= CfgDataW'(bl);
    @(posedge clk);
    sb.write_reg(CfgBinLimit, CfgDataW'(bl));
    cfg_idx  <= CfgTargets;
    cfg_data <= CfgDataW'(tpa);
    @(posedge clk);
    sb.write_reg(CfgTargets, CfgDataW'(tpa));
    cfg_idx  <= CfgOffsetLim;
    cfg_data <= CfgDataW'(off);
    @(posedge clk);
    sb.write_reg(CfgOffsetLim, CfgDataW'(off));
    cfg_we   <= 1'b0;
  endtask

  // Edge cases, first under the reset register values
  task automatic run_directed();
    send_peak(32'd0, 12'd0, 1'b1);            // empty window
    send_peak(32'd0, 12'd511, 1'b0);          // top kept bin, zero delta
    send_peak(32'd200, 12'd4095, 1'b0);       // dropped, all bin bits set
    send_peak(32'd200, 12'd512, 1'b0);        // dropped, right at the limit
    send_peak(32'd200, 12'd100, 1'b0);        // delta exactly at offset limit
    send_peak(32'd201, 12'd3, 1'b0);          // only the newest anchor in reach
    send_peak(32'd100, 12'd7, 1'b0);          // frame goes backwards
    send_peak(32'hFFFF_FFF0, 12'd300, 1'b1);  // new track near the frame wrap
    send_peak(32'd5, 12'd301, 1'b0);          // delta across the wrap
    send_peak(32'd0, 12'd4000, 1'b1);         // dropped peak still clears window
    for (int unsigned k = 0; k < 6; k++)      // last one sees the anchor cap
      send_peak(32'd10 + k, 12'(2 * k + 1), 1'b0);
    wait_idle();
    // zero bin limit drops everything
    set_config(0, 5, 200);
    send_peak(32'd50, 12'd0, 1'b1);
    send_peak(32'd60, 12'd5, 1'b0);
    wait_idle();
    // oversized bin limit, no targets: peaks stored but never paired
    set_config(1023, 0, 0);
    send_peak(32'd70, 12'd511, 1'b1);
    send_peak(32'd70, 12'd0, 1'b0);
    send_peak(32'd71, 12'd256, 1'b0);
    wait_idle();
    set_config(1023, 1, 0);
    send_peak(32'd71, 12'd255, 1'b0);
    send_peak(32'd72, 12'd1, 1'b0);
  endtask

  // Random tracks: bursts of peaks, mostly in frame order, some noise
  logic [FrameW-1:0] track_frame = '0;

  task automatic run_track_phase(int unsigned kept_goal);
    int unsigned       kept;
    int unsigned       burst;
    int unsigned       pick;
    int unsigned       lim;
    int unsigned       off;
    logic [BinInW-1:0] bin;
    logic              start;
    bit                paused;
    kept   = 0;
    paused = 1'b0;
    off    = 32'(sb.offset_limit);
    while (kept < kept_goal) begin
      burst = $urandom_range(1, 16);
      while (burst != 0 && kept < kept_goal) begin
        start = ($urandom_range(0, 39) == 0);
        pick  = $urandom_range(0, 19);
        if (start) begin
          if ($urandom_range(0, 3) == 0) track_frame = 32'hFFFF_FFFF - $urandom_range(0, 3000);
          else track_frame = $urandom;
        end else if (pick < 6) begin
          // same frame
        end else if (pick < 16) begin
          track_frame = track_frame + $urandom_range(0, off + off / 8 + 2);
        end else if (pick < 18) begin
          track_frame = track_frame + $urandom_range(0, 40);
        end else if (pick == 18) begin
          track_frame = $urandom;
        end else begin
          track_frame = track_frame - $urandom_range(1, 300);
        end
        lim = sb.kept_limit();
        if (lim != 0 && $urandom_range(0, 9) != 0) bin = BinInW'($urandom_range(0, lim - 1));
        else bin = BinInW'($urandom_range(0, 4095));
        send_peak(track_frame, bin, start);
        if (bin < lim) kept++;
        burst--;
      end
      if (!paused && kept >= kept_goal / 2) begin
        // sender waits until every owed beat is out
        paused = 1'b1;
        peak_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if ($urandom_range(0, 3) != 0) begin
        peak_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  int unsigned phase_bin_limit [PhaseCnt] = '{1023, 512, 1, 300, 200, 64, 512, 511};
  int unsigned phase_targets   [PhaseCnt] = '{63, 32, 3, 1, 8, 32, 5, 20};
  int unsigned phase_offset    [PhaseCnt] = '{16383, 300, 0, 16383, 1000, 5, 200, 2000};

  // Stimulus sequence and final verdict
  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CfgBinLimit;
    cfg_data             <= '0;
    peak_if.valid        <= 1'b0;
    peak_if.frame_number <= '0;
    peak_if.bin_number   <= '0;
    peak_if.track_start  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int unsigned p = 0; p < PhaseCnt; p++) begin
      wait_idle();
      set_config(phase_bin_limit[p], phase_targets[p], phase_offset[p]);
      run_track_phase(PhaseKept);
    end
    wait_idle();
    if (sb.errors == 0) $display("** landmark_pair_hash_generator: PASSED **");
    else $display("** landmark_pair_hash_generator: FAILED **");
    $finish;
  end

endmodule
